>>> rtl/priority_process_scheduler_defines.svh
// Assertion macros used by the checker file of the priority process scheduler.
`ifndef PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH
`define PRIORITY_PROCESS_SCHEDULER_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define PPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is high.
`define PPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/pps_pkg.sv
// Package of constants, codes and types for the priority process scheduler.
package pps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int OP_W       = 2;
  localparam int NOW_W      = 32;
  localparam int ID_W       = 16;
  localparam int DUR_W      = 16;
  localparam int PRI_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int QCOUNT_W   = 5;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SCHEDULE = 2'd1;
  localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [DUR_W-1:0] duration;
    logic [PRI_W-1:0] priority_lvl;
  } entry_t;

  typedef struct packed {
    logic            go;
    logic [OP_W-1:0] op;
    entry_t          entry;
  } q_cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                take;
    entry_t              entry;
  } q_resp_t;

  typedef struct packed {
    logic load;
    logic check;
  } slot_cmd_t;

endpackage

>>> rtl/pps_queue.sv
// Process queue: entry memory, fill count and the scan and shift sequencer.
module pps_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  pps_pkg::q_cmd_t             cmd,
  output logic                        done,
  output pps_pkg::q_resp_t            resp,
  output logic [pps_pkg::CNT_W-1:0]   count
);

  localparam int IdxW  = pps_pkg::IDX_W;
  localparam int CntW  = pps_pkg::CNT_W;
  localparam int Depth = pps_pkg::QUEUE_DEPTH;

  typedef enum logic [2:0] {
    Q_IDLE, Q_SCAN, Q_DRAIN, Q_PICK, Q_SHIFT
  } q_state_t;

  q_state_t              state;
  pps_pkg::entry_t       mem [Depth];
  pps_pkg::entry_t       rdata;
  pps_pkg::entry_t       wdata;
  pps_pkg::entry_t       best_entry;
  logic [IdxW-1:0]       raddr;
  logic [IdxW-1:0]       waddr;
  logic                  we;
  logic [CntW-1:0]       idx;
  logic [CntW-1:0]       idx_inc;
  logic [CntW-1:0]       pidx;
  logic [CntW-1:0]       best;
  logic [CntW-1:0]       j_dec;
  logic [IdxW-1:0]       waddr_p;
  logic                  wpend;
  logic                  pv;
  logic                  better;
  logic                  full;
  logic [pps_pkg::PRI_W-1:0] best_pri;

  assign idx_inc = idx + CntW'(1);
  assign j_dec   = idx - CntW'(1);
  assign full    = (count == CntW'(Depth));
  assign better  = pv && (rdata.priority_lvl > best_pri);

  // The idx counter walks the scan and, reused, the shift read pointer.
  always_comb begin
    raddr = idx[IdxW-1:0];
    we    = 1'b0;
    waddr = waddr_p;
    wdata = rdata;
    if (state == Q_IDLE) begin
      we    = cmd.go && (cmd.op == pps_pkg::OP_INSERT) && !full;
      waddr = count[IdxW-1:0];
      wdata = cmd.entry;
    end else if (state == Q_SHIFT) begin
      we = wpend;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= Q_IDLE;
      count <= '0;
      done  <= 1'b0;
      pv    <= 1'b0;
      wpend <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        Q_IDLE: begin
          if (cmd.go) begin
            resp.status <= pps_pkg::ST_DONE;
            resp.take   <= 1'b0;
            if (cmd.op == pps_pkg::OP_INSERT) begin
              done <= 1'b1;
              if (full) begin
                resp.status <= pps_pkg::ST_FULL;
              end else begin
                count <= count + CntW'(1);
              end
            end else if (cmd.op == pps_pkg::OP_SCHEDULE) begin
              if (count == '0) begin
                resp.status <= pps_pkg::ST_NONE;
                done        <= 1'b1;
              end else begin
                idx      <= '0;
                best_pri <= '0;
                pv       <= 1'b0;
                state    <= Q_SCAN;
              end
            end else begin
              done <= 1'b1;
            end
          end
        end
        Q_SCAN: begin
          if (better) begin
            best       <= pidx;
            best_pri   <= rdata.priority_lvl;
            best_entry <= rdata;
          end
          pv   <= 1'b1;
          pidx <= idx;
          idx  <= idx_inc;
          if (idx_inc == count) begin
            state <= Q_DRAIN;
          end
        end
        Q_DRAIN: begin
          if (better) begin
            best       <= pidx;
            best_pri   <= rdata.priority_lvl;
            best_entry <= rdata;
          end
          pv    <= 1'b0;
          state <= Q_PICK;
        end
        Q_PICK: begin
          if (best_pri == '0) begin
            resp.status <= pps_pkg::ST_NONE;
            done        <= 1'b1;
            state       <= Q_IDLE;
          end else begin
            idx   <= best + CntW'(1);
            wpend <= 1'b0;
            state <= Q_SHIFT;
          end
        end
        Q_SHIFT: begin
          if (idx < count) begin
            wpend   <= 1'b1;
            waddr_p <= j_dec[IdxW-1:0];
            idx     <= idx_inc;
          end else begin
            wpend <= 1'b0;
            if (!wpend) begin
              count       <= count - CntW'(1);
              resp.status <= pps_pkg::ST_DONE;
              resp.take   <= 1'b1;
              resp.entry  <= best_entry;
              done        <= 1'b1;
              state       <= Q_IDLE;
            end
          end
        end
        default: begin
          state <= Q_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/pps_slot.sv
// Scheduled slot registers and the elapsed-time completion compare.
module pps_slot (
  input  logic                          clk,
  input  logic                          rst,
  input  pps_pkg::slot_cmd_t            cmd,
  input  logic [pps_pkg::NOW_W-1:0]     now,
  input  pps_pkg::entry_t               entry,
  output logic                          running_valid,
  output logic [pps_pkg::ID_W-1:0]      running_id,
  output logic [pps_pkg::PRI_W-1:0]     running_priority,
  output logic                          running_done
);

  localparam int NowW = pps_pkg::NOW_W;

  logic                      slot_valid;
  logic                      slot_done;
  logic [pps_pkg::ID_W-1:0]  slot_id;
  logic [pps_pkg::DUR_W-1:0] slot_duration;
  logic [pps_pkg::PRI_W-1:0] slot_priority;
  logic [NowW-1:0]           slot_start;
  logic [NowW-1:0]           elapsed;
  logic                      expired;

  // Wrapping subtraction, so a tick counter roll-over is harmless.
  assign elapsed = now - slot_start;
  assign expired = (elapsed >= NowW'(slot_duration));

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid    <= 1'b0;
      slot_done     <= 1'b0;
      slot_id       <= '0;
      slot_duration <= '0;
      slot_priority <= '0;
      slot_start    <= '0;
    end else if (cmd.load) begin
      slot_valid    <= 1'b1;
      slot_done     <= 1'b0;
      slot_id       <= entry.id;
      slot_duration <= entry.duration;
      slot_priority <= entry.priority_lvl;
      slot_start    <= now;
    end else if (cmd.check && slot_valid && expired) begin
      slot_done <= 1'b1;
    end
  end

  assign running_valid    = slot_valid;
  assign running_id       = slot_valid ? slot_id : '0;
  assign running_priority = slot_valid ? slot_priority : '0;
  assign running_done     = slot_valid && slot_done;

endmodule

>>> rtl/priority_process_scheduler.sv
// Top level of the priority process scheduler: command port, sequencing and result beat.
//
// Usage. A command beat is taken at a rising edge where start is high and busy is low;
// op selects insert (append id, duration and priority), schedule (move the highest
// nonzero priority waiting entry, lowest index on ties, into the running slot) or check
// (mark the running process done once now minus its start tick reaches its duration).
// Exactly one result beat follows each command: result_strobe is high for one cycle
// and the result ports carry the status, the number of waiting entries and the
// running slot as it stands after the command. The receiver cannot stall, so the
// result is there for that single cycle only.
// Insert, check and the unused op code pass through the queue's done register and
// then the result_strobe register. A schedule scans the queue one entry per cycle
// through the single memory read port and then shifts the later entries down one
// per cycle; between the two lie the drain and pick states.
// busy is high from the accepting edge until the strobe cycle, in which a new
// command may already be taken. Reset clears the queue count and the slot;
// the entry memory is not cleared, since only entries below the count are read.
module priority_process_scheduler (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [pps_pkg::OP_W-1:0]         op,
  input  logic [pps_pkg::NOW_W-1:0]        now,
  input  logic [pps_pkg::ID_W-1:0]         proc_id,
  input  logic [pps_pkg::DUR_W-1:0]        proc_duration,
  input  logic [pps_pkg::PRI_W-1:0]        proc_priority,
  output logic                             result_strobe,
  output logic [pps_pkg::STATUS_W-1:0]     status,
  output logic [pps_pkg::QCOUNT_W-1:0]     queue_count,
  output logic                             running_valid,
  output logic [pps_pkg::ID_W-1:0]         running_id,
  output logic [pps_pkg::PRI_W-1:0]        running_priority,
  output logic                             running_done
);

  localparam int QcW = pps_pkg::QCOUNT_W;

  logic                          accept;
  logic                          active;
  logic                          q_done;
  logic [pps_pkg::OP_W-1:0]      op_q;
  logic [pps_pkg::NOW_W-1:0]     now_q;
  logic [pps_pkg::CNT_W-1:0]     q_count;
  logic [pps_pkg::STATUS_W-1:0]  status_r;
  pps_pkg::q_cmd_t               q_cmd;
  pps_pkg::q_resp_t              q_resp;
  pps_pkg::slot_cmd_t            slot_cmd;

  assign accept = start && !active;
  assign busy   = active;

  // The queue takes the insert payload straight from the ports on the accepting edge.
  assign q_cmd.go    = accept;
  assign q_cmd.op    = op;
  assign q_cmd.entry = '{id: proc_id, duration: proc_duration, priority_lvl: proc_priority};

  pps_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .cmd   (q_cmd),
    .done  (q_done),
    .resp  (q_resp),
    .count (q_count)
  );

  // The slot is updated on the edge at which the queue reports completion, using the
  // tick captured when the command was taken.
  assign slot_cmd.load  = q_done && q_resp.take;
  assign slot_cmd.check = q_done && (op_q == pps_pkg::OP_CHECK);

  pps_slot u_slot (
    .clk              (clk),
    .rst              (rst),
    .cmd              (slot_cmd),
    .now              (now_q),
    .entry            (q_resp.entry),
    .running_valid    (running_valid),
    .running_id       (running_id),
    .running_priority (running_priority),
    .running_done     (running_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= q_done;
      if (accept) begin
        active <= 1'b1;
      end else if (q_done) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= op;
      now_q <= now;
    end
    if (q_done) begin
      status_r <= q_resp.status;
    end
  end

  assign status      = status_r;
  assign queue_count = QcW'(q_count);

endmodule

>>> rtl/pps_checker.sv
// Port-level checker for the priority process scheduler, bound to the top level.
`include "priority_process_scheduler_defines.svh"

module pps_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             start,
  input logic                             busy,
  input logic [pps_pkg::QCOUNT_W-1:0]     queue_count,
  input logic [pps_pkg::STATUS_W-1:0]     status,
  input logic                             result_strobe,
  input logic                             running_valid,
  input logic [pps_pkg::ID_W-1:0]         running_id,
  input logic [pps_pkg::PRI_W-1:0]        running_priority,
  input logic                             running_done
);

  localparam int QcW = pps_pkg::QCOUNT_W;

  `PPS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !result_strobe, "accepted beat did not raise busy")
  `PPS_ASSERT_NOW(a_fell_strobe, clk, rst, $fell(busy), result_strobe, "busy fell without a result beat")
  `PPS_ASSERT_NOW(a_full_count, clk, rst, result_strobe && (status == pps_pkg::ST_FULL), queue_count == QcW'(pps_pkg::QUEUE_DEPTH), "full status with a queue that is not full")
  `PPS_ASSERT_NOW(a_empty_slot, clk, rst, result_strobe && !running_valid, (running_id == '0) && (running_priority == '0) && !running_done, "empty slot shows process data")

endmodule

bind priority_process_scheduler pps_checker u_pps_checker (.*);
